>>> hw/rtl/eprk_pkg.sv
// Shared constants, types and fixed-point helpers for the RK4 rigid-body integrator.
package eprk_pkg;

   localparam int Dim      = 3;
   localparam int FracBits = 16;
   localparam int TSize    = Dim * Dim * Dim;
   localparam int IdxW     = (Dim > 1) ? $clog2(Dim) : 1;
   localparam int TIdxW    = $clog2(TSize);
   localparam int SlotW    = 5;
   localparam int CsrIdxW  = 3;
   localparam int MulAW    = 36;
   localparam int MulBW    = 33;
   localparam int ProdW    = MulAW + MulBW;
   localparam int DvdW     = 68;
   localparam int DvsW     = 31;
   localparam int CntW     = $clog2(DvdW + 1);
   localparam int EnergyW  = 48;
   localparam int Div6W     = 80;
   localparam int Div6Steps = 5;
   localparam int Div6Shift = 22;

   localparam logic [DvsW-1:0] One       = DvsW'(1 << FracBits);
   localparam logic [DvsW-1:0] RkDivisor = DvsW'(6);
   localparam logic [19:0]     Div6Recip = 20'd699051;
   localparam logic [30:0]     StepReset = 31'd655;
   localparam logic [1:0]      SignReset = 2'b01;

   localparam logic [CsrIdxW-1:0] RegInertia0 = 3'd0;
   localparam logic [CsrIdxW-1:0] RegInertia1 = 3'd1;
   localparam logic [CsrIdxW-1:0] RegInertia2 = 3'd2;
   localparam logic [CsrIdxW-1:0] RegTimeStep = 3'd3;
   localparam logic [CsrIdxW-1:0] RegSign     = 3'd4;

   localparam logic [1:0] ReqLoadTable = 2'd0;
   localparam logic [1:0] ReqLoadVel   = 2'd1;
   localparam logic [1:0] ReqStep      = 2'd2;

   typedef struct packed {
      logic [Dim-1:0][30:0] inertia;
      logic [30:0]          dt;
      logic [1:0]           sign;
   } cfg_type;

   typedef struct packed {
      logic            start;
      logic [DvdW-1:0] dividend;
      logic [DvsW-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic            done;
      logic [DvdW-1:0] quotient;
   } div_rsp_type;

   localparam logic signed [ProdW-1:0] Max32 = ProdW'(32'h7FFF_FFFF);
   localparam logic signed [ProdW-1:0] Min32 = -Max32 - ProdW'(1);

   function automatic logic signed [ProdW-1:0] trunc_shift(
      input logic signed [ProdW-1:0] v, input int unsigned n);
      logic [ProdW-1:0] m;
      m = v[ProdW-1] ? ProdW'(-v) : ProdW'(v);
      m = m >> n;
      return v[ProdW-1] ? -$signed(m) : $signed(m);
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [ProdW-1:0] v);
      if (v > Max32) return 32'sh7FFF_FFFF;
      if (v < Min32) return 32'sh8000_0000;
      return v[31:0];
   endfunction

endpackage

>>> hw/rtl/eprk_if.sv
// Valid/ready channel interfaces for requests, results and register writes.
interface eprk_req_if;
   import eprk_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               req_type;
   logic [SlotW-1:0]         slot_index;
   logic signed [31:0]       load_value;
   modport source (output valid, req_type, slot_index, load_value, input ready);
   modport sink (input valid, req_type, slot_index, load_value, output ready);
endinterface

interface eprk_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         component;
   logic signed [31:0] velocity_value;
   logic signed [31:0] momentum_value;
   logic [30:0]        energy_value;
   logic               last;
   modport source (output valid, component, velocity_value, momentum_value,
                   energy_value, last, input ready);
   modport sink (input valid, component, velocity_value, momentum_value,
                 energy_value, last, output ready);
endinterface

interface eprk_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/euler_poincare_rk4_step_top.sv
// A step makes four derivative passes of about 60 multiplies and three bit-serial quotients
// each, then three radix-2^16 divisions by six, before the first result transaction; each
// zero inertia or zero sum drops a quotient.
// Table and velocity loads are done in the idle state; one request is in flight at a time.
// A new request is taken only once all results of a step have been accepted.
// Synchronous active-high reset zeroes velocity and table and restores register defaults.
module euler_poincare_rk4_step_top
   import eprk_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   eprk_req_if.sink   req_bus,
   eprk_rsp_if.source rsp_bus,
   eprk_csr_if.sink   csr_bus
);

   logic [30:0] inertia_ff [3];
   logic [30:0] dt_ff;
   logic [1:0]  sign_ff;
   cfg_type     cfg;

   logic signed [MulAW-1:0] mul_a;
   logic signed [MulBW-1:0] mul_b;
   logic signed [ProdW-1:0] mul_prod;
   div_req_type             div_req;
   div_rsp_type             div_rsp;

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inertia_ff[0] <= One;
         inertia_ff[1] <= One;
         inertia_ff[2] <= One;
         dt_ff         <= StepReset;
         sign_ff       <= SignReset;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            RegInertia0: inertia_ff[0] <= csr_bus.data[30:0];
            RegInertia1: inertia_ff[1] <= csr_bus.data[30:0];
            RegInertia2: inertia_ff[2] <= csr_bus.data[30:0];
            RegTimeStep: dt_ff         <= csr_bus.data[30:0];
            RegSign:     sign_ff       <= csr_bus.data[1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      for (int n = 0; n < Dim; n++) begin
         cfg.inertia[n] = (n < 3) ? inertia_ff[n] : One;
      end
      cfg.dt   = dt_ff;
      cfg.sign = sign_ff;
   end

   eprk_core u_core (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req      (req_bus),
      .rsp      (rsp_bus),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (mul_prod),
      .div_req  (div_req),
      .div_rsp  (div_rsp)
   );

   eprk_mul u_mul (
      .clock (clock),
      .mul_a (mul_a),
      .mul_b (mul_b),
      .prod  (mul_prod)
   );

   eprk_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule

>>> hw/rtl/eprk_mul.sv
// Shared signed multiplier with registered product.
module eprk_mul
   import eprk_pkg::*;
(
   input  logic                    clock,
   input  logic signed [MulAW-1:0] mul_a,
   input  logic signed [MulBW-1:0] mul_b,
   output logic signed [ProdW-1:0] prod
);

   logic signed [ProdW-1:0] prod_ff;
   logic signed [ProdW-1:0] prod_in;

   assign prod_in = ProdW'(mul_a) * ProdW'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

>>> hw/rtl/eprk_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module eprk_div
   import eprk_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic [DvdW-1:0] dvd_ff, dvd_in;
   logic [DvsW-1:0] rem_ff, rem_in;
   logic [DvsW-1:0] dvs_ff, dvs_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            done_ff, done_in;
   logic [DvsW+1:0] trial;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      trial   = {1'b0, rem_ff, dvd_ff[DvdW-1]} - {2'b00, dvs_ff};
      if (div_req.start) begin
         dvd_in = div_req.dividend;
         dvs_in = div_req.divisor;
         rem_in = '0;
         cnt_in = CntW'(DvdW);
      end else if (cnt_ff != '0) begin
         if (!trial[DvsW+1]) begin
            rem_in = trial[DvsW-1:0];
            dvd_in = {dvd_ff[DvdW-2:0], 1'b1};
         end else begin
            rem_in = {rem_ff[DvsW-2:0], dvd_ff[DvdW-1]};
            dvd_in = {dvd_ff[DvdW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = dvd_ff;

endmodule

>>> hw/rtl/eprk_core.sv
// Sequencer and state of the integrator: table, velocity, RK4 stages and results.
module eprk_core
   import eprk_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  cfg_type                 cfg,
   eprk_req_if.sink                req,
   eprk_rsp_if.source              rsp,
   output logic signed [MulAW-1:0] mul_a,
   output logic signed [MulBW-1:0] mul_b,
   input  logic signed [ProdW-1:0] mul_prod,
   output div_req_type             div_req,
   input  div_rsp_type             div_rsp
);

   localparam logic [4:0] StIdle  = 5'd0;
   localparam logic [4:0] StMu    = 5'd1;
   localparam logic [4:0] StMuW   = 5'd2;
   localparam logic [4:0] StPc    = 5'd3;
   localparam logic [4:0] StPcW   = 5'd4;
   localparam logic [4:0] StPm    = 5'd5;
   localparam logic [4:0] StPmW   = 5'd6;
   localparam logic [4:0] StDivGo = 5'd7;
   localparam logic [4:0] StDivW  = 5'd8;
   localparam logic [4:0] StKNext = 5'd9;
   localparam logic [4:0] StSt    = 5'd10;
   localparam logic [4:0] StStW   = 5'd11;
   localparam logic [4:0] StFin   = 5'd12;
   localparam logic [4:0] StFinW  = 5'd13;
   localparam logic [4:0] StFDivW = 5'd14;
   localparam logic [4:0] StMom   = 5'd15;
   localparam logic [4:0] StMomW  = 5'd16;
   localparam logic [4:0] StEn    = 5'd17;
   localparam logic [4:0] StEnW   = 5'd18;
   localparam logic [4:0] StOut   = 5'd19;

   localparam logic [IdxW-1:0] LastIdx = IdxW'(Dim - 1);

   logic [4:0]         state_ff, state_in;
   logic [1:0]         stage_ff, stage_in;
   logic [IdxW-1:0]    i_ff, i_in, k_ff, k_in, j_ff, j_in;
   logic signed [31:0] xi_ff [Dim];
   logic signed [31:0] xi_in [Dim];
   logic signed [31:0] x_ff [Dim];
   logic signed [31:0] x_in [Dim];
   logic signed [31:0] t_ff [Dim];
   logic signed [31:0] t_in [Dim];
   logic signed [31:0] mu_ff [Dim];
   logic signed [31:0] mu_in [Dim];
   logic signed [31:0] mom_ff [Dim];
   logic signed [31:0] mom_in [Dim];
   logic signed [MulAW-1:0] ksum_ff [Dim];
   logic signed [MulAW-1:0] ksum_in [Dim];
   logic signed [31:0] tbl_ff [TSize];
   logic signed [31:0] tbl_in [TSize];
   logic signed [31:0] d_ff, d_in, p_ff, p_in;
   logic signed [63:0] acc_ff, acc_in;
   logic               neg_ff, neg_in;
   logic [EnergyW-1:0] energy_ff, energy_in;
   logic [Div6W-1:0]   w6_ff, w6_in;
   logic [2:0]         r6_ff, r6_in, n6_ff, n6_in;

   logic [TIdxW-1:0]        slot;
   logic signed [63:0]      accs;
   logic signed [31:0]      a32;
   logic [32:0]             amag;
   logic signed [ProdW-1:0] qs, xs, tmp;
   logic [ProdW-1:0]        pmag;
   logic [DvdW-1:0]         inc;
   logic signed [MulAW-1:0] kadd;
   logic [18:0]             v6, r6full;
   logic [38:0]             v6p;
   logic [15:0]             q6;

   assign slot = TIdxW'(i_ff * Dim * Dim + k_ff * Dim + j_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         StMu: begin
            mul_a = MulAW'(x_ff[j_ff]);
            mul_b = $signed({2'b00, cfg.inertia[j_ff]});
         end
         StPc: begin
            mul_a = MulAW'(tbl_ff[slot]);
            mul_b = MulBW'(x_ff[k_ff]);
         end
         StPm: begin
            mul_a = MulAW'(p_ff);
            mul_b = MulBW'(mu_ff[j_ff]);
         end
         StSt: begin
            mul_a = MulAW'(d_ff);
            mul_b = $signed({2'b00, cfg.dt});
         end
         StFin: begin
            mul_a = ksum_ff[i_ff];
            mul_b = $signed({2'b00, cfg.dt});
         end
         StMom: begin
            mul_a = MulAW'(xi_ff[i_ff]);
            mul_b = $signed({2'b00, cfg.inertia[i_ff]});
         end
         StEn: begin
            mul_a = MulAW'(xi_ff[i_ff]);
            mul_b = MulBW'(mom_ff[i_ff]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      stage_in  = stage_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      j_in      = j_ff;
      xi_in     = xi_ff;
      x_in      = x_ff;
      t_in      = t_ff;
      mu_in     = mu_ff;
      mom_in    = mom_ff;
      ksum_in   = ksum_ff;
      tbl_in    = tbl_ff;
      d_in      = d_ff;
      p_in      = p_ff;
      acc_in    = acc_ff;
      neg_in    = neg_ff;
      energy_in = energy_ff;
      w6_in     = w6_ff;
      r6_in     = r6_ff;
      n6_in     = n6_ff;
      div_req   = '0;
      req.ready = 1'b0;
      accs      = acc_ff[1] ? -acc_ff : acc_ff;
      if (cfg.sign[1]) begin
         accs = -acc_ff;
      end else if (cfg.sign == 2'b00) begin
         accs = '0;
      end else begin
         accs = acc_ff;
      end
      a32  = sat32({{(ProdW-64){accs[63]}}, accs});
      amag = a32[31] ? -{a32[31], a32} : {a32[31], a32};
      qs   = $signed({1'b0, div_rsp.quotient});
      xs   = ProdW'(xi_ff[i_ff]);
      pmag = mul_prod[ProdW-1] ? ProdW'(-mul_prod) : ProdW'(mul_prod);
      v6     = {r6_ff, w6_ff[Div6W-1 -: 16]};
      v6p    = 39'(v6) * 39'(Div6Recip);
      q6     = v6p[Div6Shift +: 16];
      r6full = v6 - 19'(q6) * 19'(RkDivisor);
      inc  = w6_ff[DvdW-1:0] >> FracBits;
      kadd = (stage_ff == 2'd1 || stage_ff == 2'd2) ? MulAW'(d_ff) <<< 1 : MulAW'(d_ff);
      tmp  = '0;

      unique case (state_ff)
         StIdle: begin
            req.ready = 1'b1;
            if (req.valid) begin
               case (req.req_type)
                  ReqLoadTable: begin
                     if (req.slot_index < SlotW'(TSize)) begin
                        tbl_in[TIdxW'(req.slot_index)] = req.load_value;
                     end
                  end
                  ReqLoadVel: begin
                     if (req.slot_index < SlotW'(Dim)) begin
                        xi_in[IdxW'(req.slot_index)] = req.load_value;
                     end
                  end
                  ReqStep: begin
                     x_in     = xi_ff;
                     stage_in = '0;
                     j_in     = '0;
                     for (int n = 0; n < Dim; n++) begin
                        ksum_in[n] = '0;
                     end
                     state_in = StMu;
                  end
                  default: begin
                  end
               endcase
            end
         end
         StMu: state_in = StMuW;
         StMuW: begin
            mu_in[j_ff] = sat32(trunc_shift(mul_prod, FracBits));
            if (j_ff == LastIdx) begin
               i_in     = '0;
               k_in     = '0;
               j_in     = '0;
               acc_in   = '0;
               state_in = StPc;
            end else begin
               j_in     = j_ff + IdxW'(1);
               state_in = StMu;
            end
         end
         StPc: state_in = StPcW;
         StPcW: begin
            p_in     = sat32(trunc_shift(mul_prod, FracBits));
            state_in = StPm;
         end
         StPm: state_in = StPmW;
         StPmW: begin
            tmp      = trunc_shift(mul_prod, FracBits);
            acc_in   = acc_ff + tmp[63:0];
            state_in = StPc;
            if (j_ff == LastIdx) begin
               j_in = '0;
               if (k_ff == LastIdx) begin
                  k_in     = '0;
                  state_in = StDivGo;
               end else begin
                  k_in = k_ff + IdxW'(1);
               end
            end else begin
               j_in = j_ff + IdxW'(1);
            end
         end
         StDivGo: begin
            if (cfg.inertia[i_ff] == '0 || a32 == '0) begin
               d_in     = '0;
               state_in = StKNext;
            end else begin
               neg_in           = a32[31];
               div_req.start    = 1'b1;
               div_req.dividend = DvdW'(amag) << FracBits;
               div_req.divisor  = cfg.inertia[i_ff];
               state_in         = StDivW;
            end
         end
         StDivW: begin
            if (div_rsp.done) begin
               d_in     = sat32(neg_ff ? -qs : qs);
               state_in = StKNext;
            end
         end
         StKNext: begin
            ksum_in[i_ff] = ksum_ff[i_ff] + kadd;
            if (stage_ff == 2'd3) begin
               if (i_ff == LastIdx) begin
                  i_in     = '0;
                  state_in = StFin;
               end else begin
                  i_in     = i_ff + IdxW'(1);
                  acc_in   = '0;
                  state_in = StPc;
               end
            end else begin
               state_in = StSt;
            end
         end
         StSt: state_in = StStW;
         StStW: begin
            tmp = trunc_shift(mul_prod, (stage_ff == 2'd2) ? FracBits : FracBits + 1);
            t_in[i_ff] = sat32(xs + tmp);
            if (i_ff == LastIdx) begin
               i_in     = '0;
               x_in     = t_in;
               stage_in = stage_ff + 2'd1;
               j_in     = '0;
               state_in = StMu;
            end else begin
               i_in     = i_ff + IdxW'(1);
               acc_in   = '0;
               state_in = StPc;
            end
         end
         StFin: state_in = StFinW;
         StFinW: begin
            neg_in = mul_prod[ProdW-1];
            if (pmag == '0) begin
               if (i_ff == LastIdx) begin
                  i_in      = '0;
                  energy_in = '0;
                  state_in  = StMom;
               end else begin
                  i_in     = i_ff + IdxW'(1);
                  state_in = StFin;
               end
            end else begin
               w6_in    = Div6W'(pmag[DvdW-1:0]);
               r6_in    = '0;
               n6_in    = 3'(Div6Steps);
               state_in = StFDivW;
            end
         end
         StFDivW: begin
            if (n6_ff != '0) begin
               w6_in = {w6_ff[Div6W-17:0], q6};
               r6_in = r6full[2:0];
               n6_in = n6_ff - 3'd1;
            end else begin
               tmp = $signed({1'b0, inc});
               xi_in[i_ff] = sat32(neg_ff ? xs - tmp : xs + tmp);
               if (i_ff == LastIdx) begin
                  i_in      = '0;
                  energy_in = '0;
                  state_in  = StMom;
               end else begin
                  i_in     = i_ff + IdxW'(1);
                  state_in = StFin;
               end
            end
         end
         StMom: state_in = StMomW;
         StMomW: begin
            mom_in[i_ff] = sat32(trunc_shift(mul_prod, FracBits));
            state_in     = StEn;
         end
         StEn: state_in = StEnW;
         StEnW: begin
            tmp = trunc_shift(mul_prod, FracBits + 1);
            if (tmp > 0) begin
               energy_in = energy_ff + tmp[EnergyW-1:0];
            end
            if (i_ff == LastIdx) begin
               i_in     = '0;
               state_in = StOut;
            end else begin
               i_in     = i_ff + IdxW'(1);
               state_in = StMom;
            end
         end
         StOut: begin
            if (rsp.ready) begin
               if (i_ff == LastIdx) begin
                  i_in     = '0;
                  state_in = StIdle;
               end else begin
                  i_in = i_ff + IdxW'(1);
               end
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      t_ff      <= t_in;
      mu_ff     <= mu_in;
      mom_ff    <= mom_in;
      ksum_ff   <= ksum_in;
      d_ff      <= d_in;
      p_ff      <= p_in;
      acc_ff    <= acc_in;
      neg_ff    <= neg_in;
      energy_ff <= energy_in;
      w6_ff     <= w6_in;
      r6_ff     <= r6_in;
      n6_ff     <= n6_in;
      k_ff      <= k_in;
      j_ff      <= j_in;
      stage_ff  <= stage_in;
      if (reset) begin
         state_ff <= StIdle;
         i_ff     <= '0;
         for (int n = 0; n < Dim; n++) begin
            xi_ff[n] <= '0;
         end
         for (int n = 0; n < TSize; n++) begin
            tbl_ff[n] <= '0;
         end
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         xi_ff    <= xi_in;
         tbl_ff   <= tbl_in;
      end
   end

   assign rsp.valid          = (state_ff == StOut);
   assign rsp.component      = 2'(i_ff);
   assign rsp.velocity_value = xi_ff[i_ff];
   assign rsp.momentum_value = mom_ff[i_ff];
   assign rsp.last           = (i_ff == LastIdx);
   assign rsp.energy_value   = (i_ff != LastIdx) ? 31'd0 :
                               (energy_ff > EnergyW'(32'h7FFF_FFFF)) ? 31'h7FFF_FFFF :
                               energy_ff[30:0];

endmodule

>>> hw/rtl/eprk_checker.sv
// Port-level checks of the integrator and their attachment to the top level.
module eprk_props
   import eprk_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic [1:0]        req_type,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic              rsp_last,
   input logic [30:0]       rsp_energy,
   input logic signed [31:0] rsp_velocity
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_velocity))
      else $error("stalled result transaction changed");

   a_step_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == ReqStep |=> !req_ready)
      else $error("request taken during a step");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted while results pending");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> !rsp_valid)
      else $error("result after last transaction");

   a_energy_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_energy == '0)
      else $error("energy on a non-final result");

endmodule

bind euler_poincare_rk4_step_top eprk_props u_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_type     (req_bus.req_type),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_last     (rsp_bus.last),
   .rsp_energy   (rsp_bus.energy_value),
   .rsp_velocity (rsp_bus.velocity_value)
);

>>> verif/eprk_checker.sv
// Checker for the RK4 rigid-body integrator: predicts every result and compares it.
`timescale 1ns / 100ps
module eprk_checker
   import eprk_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   eprk_req_if    req_bus,
   eprk_rsp_if    rsp_bus,
   eprk_csr_if    csr_bus,
   output int     fail_count,
   output int     pending_count
);

   localparam longint Unit = longint'(1) << FracBits;

   typedef longint vec_type [Dim];

   typedef struct {
      logic [1:0]         component;
      logic signed [31:0] velocity_value;
      logic signed [31:0] momentum_value;
      logic [30:0]        energy_value;
      logic               last;
   } body_result_type;

   body_result_type awaited_results [$];

   longint     vel_state [Dim];
   longint     bracket_table [TSize];
   longint     axis_inertia [Dim];
   longint     step_dt;
   logic [1:0] coadjoint_sign;

   assign pending_count = awaited_results.size();

   function automatic longint clamp32(input longint v);
      if (v > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (v < -64'sh8000_0000) return -64'sh8000_0000;
      return v;
   endfunction

   function automatic longint inertia_at(input int i);
      return (i < 3) ? axis_inertia[i] : Unit;
   endfunction

   function automatic vec_type rate_of(input vec_type x);
      vec_type mu;
      vec_type d;
      longint acc;
      longint p;
      longint inr;
      for (int j = 0; j < Dim; j++) mu[j] = clamp32(inertia_at(j) * x[j] / Unit);
      for (int i = 0; i < Dim; i++) begin
         acc = 0;
         inr = inertia_at(i);
         for (int k = 0; k < Dim; k++)
            for (int j = 0; j < Dim; j++) begin
               p = clamp32(bracket_table[i*Dim*Dim + k*Dim + j] * x[k] / Unit);
               acc += p * mu[j] / Unit;
            end
         if (coadjoint_sign[1]) acc = -acc;
         else if (coadjoint_sign == 2'b00) acc = 0;
         acc = clamp32(acc);
         d[i] = (inr == 0) ? 0 : clamp32(acc * Unit / inr);
      end
      return d;
   endfunction

   function automatic vec_type stage_of(input vec_type k, input longint div);
      vec_type t;
      for (int i = 0; i < Dim; i++) t[i] = clamp32(vel_state[i] + step_dt * k[i] / div);
      return t;
   endfunction

   task automatic predict_step();
      vec_type k1, k2, k3, k4, x, t;
      longint s, inc, e, energy;
      longint unsigned mag, q, r, m;
      longint mom [Dim];
      body_result_type res;
      for (int i = 0; i < Dim; i++) x[i] = vel_state[i];
      k1 = rate_of(x);
      t  = stage_of(k1, 2 * Unit);
      k2 = rate_of(t);
      t  = stage_of(k2, 2 * Unit);
      k3 = rate_of(t);
      t  = stage_of(k3, Unit);
      k4 = rate_of(t);
      for (int i = 0; i < Dim; i++) begin
         s   = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
         mag = (s < 0) ? longint'(-s) : longint'(s);
         q   = mag / 6;
         r   = mag % 6;
         m   = longint'(step_dt) * q + (longint'(step_dt) * r) / 6;
         inc = longint'(m >> FracBits);
         vel_state[i] = clamp32((s < 0) ? vel_state[i] - inc : vel_state[i] + inc);
      end
      energy = 0;
      for (int i = 0; i < Dim; i++) begin
         mom[i] = clamp32(inertia_at(i) * vel_state[i] / Unit);
         e = vel_state[i] * mom[i] / (2 * Unit);
         if (e > 0) energy += e;
      end
      if (energy > 64'sh7FFF_FFFF) energy = 64'sh7FFF_FFFF;
      for (int i = 0; i < Dim; i++) begin
         res.component      = 2'(i);
         res.velocity_value = vel_state[i][31:0];
         res.momentum_value = mom[i][31:0];
         res.energy_value   = (i == Dim - 1) ? energy[30:0] : 31'd0;
         res.last           = (i == Dim - 1);
         awaited_results.push_back(res);
      end
   endtask

   always @(posedge clock) begin
      body_result_type exp_res;
      if (reset) begin
         for (int i = 0; i < Dim; i++) vel_state[i] = 0;
         for (int i = 0; i < TSize; i++) bracket_table[i] = 0;
         for (int i = 0; i < Dim; i++) axis_inertia[i] = Unit;
         step_dt = 655;
         coadjoint_sign = SignReset;
         awaited_results.delete();
         fail_count <= 0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               RegInertia0: axis_inertia[0] = longint'(csr_bus.data[30:0]);
               RegInertia1: axis_inertia[1] = longint'(csr_bus.data[30:0]);
               RegInertia2: axis_inertia[2] = longint'(csr_bus.data[30:0]);
               RegTimeStep: step_dt = longint'(csr_bus.data[30:0]);
               RegSign:     coadjoint_sign = csr_bus.data[1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready) begin
            case (req_bus.req_type)
               ReqLoadTable:
                  if (req_bus.slot_index < TSize)
                     bracket_table[req_bus.slot_index] = longint'(req_bus.load_value);
               ReqLoadVel:
                  if (req_bus.slot_index < Dim)
                     vel_state[req_bus.slot_index] = longint'(req_bus.load_value);
               ReqStep: predict_step();
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected result transaction, component %0d", rsp_bus.component);
               fail_count <= fail_count + 1;
            end else begin
               exp_res = awaited_results.pop_front();
               if (rsp_bus.component !== exp_res.component ||
                   rsp_bus.velocity_value !== exp_res.velocity_value ||
                   rsp_bus.momentum_value !== exp_res.momentum_value ||
                   rsp_bus.energy_value !== exp_res.energy_value ||
                   rsp_bus.last !== exp_res.last)
                  fail_count <= fail_count + 1;
               if (rsp_bus.component !== exp_res.component)
                  $error("component: expected %0d, got %0d",
                         exp_res.component, rsp_bus.component);
               if (rsp_bus.velocity_value !== exp_res.velocity_value)
                  $error("velocity_value: expected %0d, got %0d",
                         exp_res.velocity_value, rsp_bus.velocity_value);
               if (rsp_bus.momentum_value !== exp_res.momentum_value)
                  $error("momentum_value: expected %0d, got %0d",
                         exp_res.momentum_value, rsp_bus.momentum_value);
               if (rsp_bus.energy_value !== exp_res.energy_value)
                  $error("energy_value: expected %0d, got %0d",
                         exp_res.energy_value, rsp_bus.energy_value);
               if (rsp_bus.last !== exp_res.last)
                  $error("last: expected %0d, got %0d", exp_res.last, rsp_bus.last);
            end
         end
      end
   end

endmodule

>>> verif/testbench.sv
// Stimulus and verdict for the RK4 rigid-body integrator.
`timescale 1ns / 100ps
module testbench;
   import eprk_pkg::*;

   localparam int CycleLimit = 3_000_000;
   localparam int HoldCycles = 4000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   logic hold_request = 1'b0;

   eprk_req_if req_bus ();
   eprk_rsp_if rsp_bus ();
   eprk_csr_if csr_bus ();

   euler_poincare_rk4_step_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   eprk_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req_bus),
      .rsp_bus       (rsp_bus),
      .csr_bus       (csr_bus),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int hold_left;
      rsp_bus.ready = 1'b0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request && hold_left == 0) hold_left = HoldCycles;
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_item(input logic [1:0] kind, input logic [SlotW-1:0] slot,
                            input logic [31:0] value);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= kind;
      req_bus.slot_index <= slot;
      req_bus.load_value <= value;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (50) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1 << 19)) - (1 << 18));
      endcase
   endfunction

   task automatic set_config(input int mode);
      case (mode)
         0: begin
            write_reg(RegInertia0, 32'h0001_0000);
            write_reg(RegInertia1, 32'h0002_0000);
            write_reg(RegInertia2, 32'h0000_8000);
            write_reg(RegTimeStep, 32'd655);
            write_reg(RegSign, 32'd1);
         end
         1: begin
            write_reg(RegInertia0, 32'h7FFF_FFFF);
            write_reg(RegInertia1, 32'hFFFF_FFFF);
            write_reg(RegInertia2, 32'd0);
            write_reg(RegTimeStep, 32'h7FFF_FFFF);
            write_reg(RegSign, 32'd3);
         end
         2: begin
            write_reg(RegInertia0, 32'd0);
            write_reg(RegInertia1, 32'd1);
            write_reg(RegInertia2, 32'h0003_0000);
            write_reg(RegTimeStep, 32'd0);
            write_reg(RegSign, 32'd0);
         end
         3: begin
            write_reg(RegInertia0, $urandom);
            write_reg(RegInertia1, $urandom);
            write_reg(RegInertia2, $urandom);
            write_reg(RegTimeStep, $urandom);
            write_reg(RegSign, 32'd2);
         end
         default: begin
            write_reg(RegInertia0, $urandom_range(1, 1 << 18));
            write_reg(RegInertia1, $urandom_range(1, 1 << 18));
            write_reg(RegInertia2, $urandom_range(1, 1 << 18));
            write_reg(RegTimeStep, $urandom_range(1, 1 << 14));
            write_reg(RegSign, $urandom);
            write_reg(3'($urandom_range(5, 7)), $urandom);
         end
      endcase
   endtask

   initial begin
      int r;
      req_bus.valid      = 1'b0;
      req_bus.req_type   = ReqLoadTable;
      req_bus.slot_index = '0;
      req_bus.load_value = '0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = RegInertia0;
      csr_bus.data       = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // step from reset, then extremes, ignored slots and the unknown request
      send_item(ReqStep, 5'd0, 32'd0);
      send_item(ReqLoadVel, 5'd0, 32'h7FFF_FFFF);
      send_item(ReqLoadVel, 5'd1, 32'h8000_0000);
      send_item(ReqLoadVel, 5'd2, 32'h0001_0000);
      send_item(ReqLoadVel, 5'd3, 32'h1234_5678);
      send_item(ReqLoadTable, 5'd0, 32'h7FFF_FFFF);
      send_item(ReqLoadTable, 5'd5, 32'h8000_0000);
      send_item(ReqLoadTable, 5'd26, 32'hFFFF_0000);
      send_item(ReqLoadTable, 5'd27, 32'h0001_0000);
      send_item(ReqLoadTable, 5'd31, 32'hFFFF_FFFF);
      send_item(2'd3, 5'd1, 32'h0001_0000);
      send_item(ReqStep, 5'd31, 32'hFFFF_FFFF);
      drain();
      set_config(1);
      send_item(ReqStep, 5'd0, 32'd0);
      drain();
      set_config(2);
      send_item(ReqStep, 5'd0, 32'd0);
      drain();
      set_config(3);
      send_item(ReqStep, 5'd0, 32'd0);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         send_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 64 : 0;
         recv_idle_pct = (phase < 2) ? 64 : (phase < 4) ? 20 : 0;
         set_config((phase == 0) ? 0 : (phase == 3) ? 1 : (phase == 5) ? 2 : 4);
         for (int n = 0; n < 52; n++) begin
            if (phase == 1 && n == 10) hold_request = 1'b1;
            if (phase == 1 && n == 12) hold_request = 1'b0;
            r = $urandom_range(0, 99);
            if (r < 8)
               send_item(2'($urandom), 5'($urandom), $urandom);
            else if (r < 45)
               send_item(ReqLoadTable, 5'($urandom_range(0, TSize - 1)), pick_value());
            else if (r < 70)
               send_item(ReqLoadVel, 5'($urandom_range(0, Dim - 1)), pick_value());
            else
               send_item(ReqStep, 5'($urandom), $urandom);
         end
         drain();
      end

      repeat (2000) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

>>> euler_poincare_rk4_step_top.f
hw/rtl/eprk_pkg.sv
hw/rtl/eprk_if.sv
hw/rtl/eprk_mul.sv
hw/rtl/eprk_div.sv
hw/rtl/eprk_core.sv
hw/rtl/euler_poincare_rk4_step_top.sv
hw/rtl/eprk_checker.sv
verif/eprk_checker.sv
verif/testbench.sv
